/* hdl/jmsc_pkg.sv */
`default_nettype none

package jmsc_pkg;

  // Marker code bytes
  localparam logic [7:0] MarkerPrefix = 8'hFF;
  localparam logic [7:0] CodeSoi      = 8'hD8;
  localparam logic [7:0] CodeEoi      = 8'hD9;
  localparam logic [7:0] CodeRstFirst = 8'hD0;
  localparam logic [7:0] CodeRstLast  = 8'hD7;
  localparam logic [7:0] CodeSos      = 8'hDA;
  localparam logic [7:0] CodeStuffed  = 8'h00;

  localparam int unsigned OutDataWidth = 16;

  typedef enum logic [5:0] {
    PH_PREFIX    = 6'b000001,
    PH_CODE      = 6'b000010,
    PH_LEN_HI    = 6'b000100,
    PH_LEN_LO    = 6'b001000,
    PH_SKIP      = 6'b010000,
    PH_AFTER_EOI = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    V_PENDING    = 3'd0,
    V_OK         = 3'd1,
    V_SHORT      = 3'd2,
    V_NO_PREFIX  = 3'd3,
    V_STRAY_ZERO = 3'd4,
    V_TRAILING   = 3'd5
  } verdict_e;

  typedef struct packed {
    phase_e      phase;
    logic        in_scan_data;
    logic [7:0]  length_high;
    logic [15:0] skip_remaining;
    logic        verdict_given;
  } chk_state_t;

  typedef struct packed {
    logic       entropy_mode;
    logic [7:0] marker_code;
    logic       marker_valid;
    verdict_e   verdict;
    logic       verdict_valid;
  } chk_result_t;

  localparam chk_state_t StateReset = '{
    phase:          PH_PREFIX,
    in_scan_data:   1'b0,
    length_high:    8'h00,
    skip_remaining: 16'h0000,
    verdict_given:  1'b0
  };

endpackage

`default_nettype wire

/* hdl/jpeg_marker_structure_checker.sv */
`default_nettype none

// Channel  | Dir | Signals                         | Contents
// ---------+-----+---------------------------------+---------------------------------------
// s_axis   | in  | tvalid, tready, tdata[7:0],     | tdata: data_byte
//          |     | tuser[0]                        | tuser: end_of_file
// m_axis   | out | tvalid, tready, tdata[15:0]     | tdata: verdict_valid, verdict[2:0],
//          |     |                                 | marker_valid, marker_code[7:0],
//          |     |                                 | entropy_mode, 2 zero bits
//
// One result transfer for every input transfer, in order.
// Throughput: one item per cycle while the master side keeps taking results; an
// input transfer goes into the input register, then through the step logic into the result register.
// The checker state advances when an item moves from the input register into
// the result register, so a stalled master side holds everything upstream.
// rst_ni (async, active low) empties both registers and returns the checker to
// "expect 0xFF prefix", outside scan data, no verdict given.
// s_axis_tready stays high while the input register is empty or the result
// register is free or being taken.
module jpeg_marker_structure_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] verdict_valid, [3:1] verdict, [4] marker_valid, [12:5] marker_code,
  // [13] entropy_mode, [15:14] zero
  output logic [jmsc_pkg::OutDataWidth-1:0] m_axis_tdata
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_eof_q;

  // checker state
  jmsc_pkg::chk_state_t  state_q, state_d;
  jmsc_pkg::chk_result_t step_result;
  jmsc_pkg::chk_result_t out_result;

  logic out_free;
  logic advance;
  logic in_accept;

  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_accept || (in_valid_q && !out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= s_axis_tdata;
      in_eof_q  <= s_axis_tuser[0];
    end
  end

  jmsc_step u_step (
    .state_i       (state_q),
    .data_byte_i   (in_byte_q),
    .end_of_file_i (in_eof_q),
    .state_o       (state_d),
    .result_o      (step_result)
  );

  // state commits only when the item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jmsc_pkg::StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  jmsc_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (step_result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {2'b00, out_result};

endmodule

`default_nettype wire

/* hdl/jmsc_step.sv */
`default_nettype none

// Next-state and result logic for one byte or end-of-file item.
module jmsc_step (
  input  jmsc_pkg::chk_state_t  state_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_file_i,
  output jmsc_pkg::chk_state_t  state_o,
  output jmsc_pkg::chk_result_t result_o
);

  logic [15:0] seg_len;
  logic [15:0] skip_dec;
  logic        vv;
  jmsc_pkg::verdict_e vcode;
  logic        mv;
  logic [7:0]  mcode;
  jmsc_pkg::chk_state_t nxt;

  assign seg_len  = {state_i.length_high, data_byte_i};
  assign skip_dec = state_i.skip_remaining - 16'd1;

  always_comb begin
    nxt   = state_i;
    vv    = 1'b0;
    vcode = jmsc_pkg::V_PENDING;
    mv    = 1'b0;
    mcode = 8'h00;
    if (end_of_file_i) begin
      if (!state_i.verdict_given) begin
        vv    = 1'b1;
        vcode = (state_i.phase == jmsc_pkg::PH_AFTER_EOI) ? jmsc_pkg::V_OK
                                                          : jmsc_pkg::V_SHORT;
      end
      nxt = jmsc_pkg::StateReset;
    end else if (!state_i.verdict_given) begin
      case (state_i.phase)
        jmsc_pkg::PH_CODE: begin
          if (data_byte_i == jmsc_pkg::CodeStuffed) begin
            if (state_i.in_scan_data) begin
              nxt.phase = jmsc_pkg::PH_PREFIX;
            end else begin
              vv    = 1'b1;
              vcode = jmsc_pkg::V_STRAY_ZERO;
            end
          end else begin
            mv    = 1'b1;
            mcode = data_byte_i;
            if (data_byte_i inside {[jmsc_pkg::CodeRstFirst:jmsc_pkg::CodeRstLast]}) begin
              nxt.phase = jmsc_pkg::PH_PREFIX;
            end else begin
              nxt.in_scan_data = 1'b0;
              if (data_byte_i == jmsc_pkg::CodeSoi) begin
                nxt.phase = jmsc_pkg::PH_PREFIX;
              end else if (data_byte_i == jmsc_pkg::CodeEoi) begin
                nxt.phase = jmsc_pkg::PH_AFTER_EOI;
              end else begin
                nxt.in_scan_data = (data_byte_i == jmsc_pkg::CodeSos);
                nxt.phase        = jmsc_pkg::PH_LEN_HI;
              end
            end
          end
        end
        jmsc_pkg::PH_LEN_HI: begin
          nxt.length_high = data_byte_i;
          nxt.phase       = jmsc_pkg::PH_LEN_LO;
        end
        jmsc_pkg::PH_LEN_LO: begin
          // lengths of 2 or less skip nothing
          if (seg_len <= 16'd2) begin
            nxt.skip_remaining = 16'h0000;
            nxt.phase          = jmsc_pkg::PH_PREFIX;
          end else begin
            nxt.skip_remaining = seg_len - 16'd2;
            nxt.phase          = jmsc_pkg::PH_SKIP;
          end
        end
        jmsc_pkg::PH_SKIP: begin
          nxt.skip_remaining = skip_dec;
          if (skip_dec == 16'h0000) begin
            nxt.phase = jmsc_pkg::PH_PREFIX;
          end
        end
        jmsc_pkg::PH_AFTER_EOI: begin
          vv    = 1'b1;
          vcode = jmsc_pkg::V_TRAILING;
        end
        default: begin
          if (data_byte_i == jmsc_pkg::MarkerPrefix) begin
            nxt.phase = jmsc_pkg::PH_CODE;
          end else if (!state_i.in_scan_data) begin
            vv    = 1'b1;
            vcode = jmsc_pkg::V_NO_PREFIX;
          end
        end
      endcase
      if (vv) begin
        nxt.verdict_given = 1'b1;
      end
    end
  end

  assign state_o = nxt;

  assign result_o.verdict_valid = vv;
  assign result_o.verdict       = vcode;
  assign result_o.marker_valid  = mv;
  assign result_o.marker_code   = mcode;
  assign result_o.entropy_mode  = nxt.in_scan_data;

endmodule

`default_nettype wire

/* hdl/jmsc_out_reg.sv */
`default_nettype none

// Result register toward the master side; frees itself when taken.
module jmsc_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  jmsc_pkg::chk_result_t result_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output jmsc_pkg::chk_result_t result_o
);

  logic                  valid_q, valid_d;
  jmsc_pkg::chk_result_t data_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule

`default_nettype wire

/* hdl/jmsc_checker.sv */
`default_nettype none

module jmsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // verdict code only with verdict_valid
  a_verdict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[3:1] == jmsc_pkg::V_PENDING)
    else $error("verdict code without verdict_valid");

  // a given verdict is never pending and never out of range
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |->
      (m_axis_tdata[3:1] != jmsc_pkg::V_PENDING &&
       m_axis_tdata[3:1] <= jmsc_pkg::V_TRAILING))
    else $error("bad verdict code");

  // marker code only with marker_valid, never together with a verdict, and the top two bits zero
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[12:5] == 8'h00)
    else $error("marker code without marker_valid");

  a_marker_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[0]) &&
                      m_axis_tdata[15:14] == 2'b00)
    else $error("marker and verdict in one result");

endmodule

bind jpeg_marker_structure_checker jmsc_checker u_jmsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
